[src/dma4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dma4_pkg;

	typedef enum logic [1:0] {
		CMD_RD   = 2'd0,
		CMD_WR   = 2'd1,
		CMD_MRD  = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	localparam logic [1:0] KIND_RESP = 2'd0;
	localparam logic [1:0] KIND_MRD  = 2'd1;
	localparam logic [1:0] KIND_MWR  = 2'd2;

	localparam logic [15:0] REG_MASK  = 16'hFFFC;
	localparam logic [15:0] REG_ID    = 16'h0000;
	localparam logic [15:0] REG_GSTAT = 16'h0004;
	localparam logic [15:0] REG_GCTL  = 16'h0008;
	localparam logic [15:0] REG_CSEL  = 16'h000C;
	localparam logic [15:0] REG_SRCL  = 16'h0010;
	localparam logic [15:0] REG_SRCH  = 16'h0014;
	localparam logic [15:0] REG_DSTL  = 16'h0018;
	localparam logic [15:0] REG_DSTH  = 16'h001C;
	localparam logic [15:0] REG_LEN   = 16'h0020;
	localparam logic [15:0] REG_CCTL  = 16'h0024;
	localparam logic [15:0] REG_CSTAT = 16'h0028;
	localparam logic [15:0] REG_ATTR  = 16'h002C;
	localparam logic [15:0] REG_FILL  = 16'h0030;

	localparam logic [31:0] ID_VALUE = 32'h0001_0001;

	localparam logic [2:0] FL_BUSY = 3'b001;
	localparam logic [2:0] FL_DONE = 3'b010;
	localparam logic [2:0] FL_ERR  = 3'b100;

	typedef struct packed {
		logic [1:0]  kind;
		logic        hit;
		logic [7:0]  rdata;
		logic [15:0] mem_addr;
		logic [7:0]  mem_wdata;
		logic        last;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic acc;   // item taken this cycle
		logic sel1;  // second result on the output
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] nres;  // results caused by the item on the input
		logic       selw;  // item writes channel select
	} sts_t;

	function automatic logic [31:0] merge32(input logic [31:0] old, input logic [7:0] b,
		input logic [1:0] lane);
		logic [31:0] r;
		r = old;
		r[{lane, 3'b000} +: 8] = b;
		return r;
	endfunction

endpackage
`default_nettype wire

[src/dma4_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dma4_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] addr;
	logic [7:0]  wdata;
	logic [7:0]  mem_rdata;
	modport source (output valid, cmd, addr, wdata, mem_rdata, input ready);
	modport sink (input valid, cmd, addr, wdata, mem_rdata, output ready);
endinterface

interface dma4_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        hit;
	logic [7:0]  rdata;
	logic [15:0] mem_addr;
	logic [7:0]  mem_wdata;
	logic        last;
	modport source (output valid, kind, hit, rdata, mem_addr, mem_wdata, last, input ready);
	modport sink (input valid, kind, hit, rdata, mem_addr, mem_wdata, last, output ready);
endinterface

interface dma4_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[src/dma4_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module dma4_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	input  wire dma4_pkg::sts_t sts,
	output dma4_pkg::ctl_t   ctl
);
	import dma4_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND0,
		ST_SEND1,
		ST_SETTLE
	} state_t;

	state_t     state_q;
	logic [1:0] nres_q;
	logic       selw_q;
	logic [1:0] cnt_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SEND0) || (state_q == ST_SEND1);
	assign ctl.acc   = in_valid && in_ready;
	assign ctl.sel1  = (state_q == ST_SEND1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nres_q  <= 2'd0;
			selw_q  <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						nres_q <= sts.nres;
						selw_q <= sts.selw;
						cnt_q  <= 2'd2;
						if (sts.nres != 2'd0) state_q <= ST_SEND0;
						else if (sts.selw) state_q <= ST_SETTLE;
					end
				end
				ST_SEND0: begin
					if (out_ready) begin
						if (nres_q == 2'd2) state_q <= ST_SEND1;
						else if (selw_q) state_q <= ST_SETTLE;
						else state_q <= ST_IDLE;
					end
				end
				ST_SEND1: begin
					if (out_ready) begin
						if (selw_q) state_q <= ST_SETTLE;
						else state_q <= ST_IDLE;
					end
				end
				ST_SETTLE: begin
					// channel index pipeline catches up
					if (cnt_q == 2'd0) state_q <= ST_IDLE;
					else cnt_q <= cnt_q - 2'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[src/dma4_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module dma4_dpath #(
	parameter int CHANNELS     = 4,
	parameter int WINDOW_BYTES = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [1:0]       cmd,
	input  wire  [15:0]      addr,
	input  wire  [7:0]       wdata,
	input  wire  [7:0]       mem_rdata,
	input  wire              cfg_we,
	input  wire  [15:0]      cfg_data,
	input  wire dma4_pkg::ctl_t ctl,
	output dma4_pkg::sts_t   sts,
	output dma4_pkg::res_t   res
);
	import dma4_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [13:0] W0 = 14'(1 % CHANNELS);
	localparam logic [13:0] W1 = 14'(256 % CHANNELS);
	localparam logic [13:0] W2 = 14'(65536 % CHANNELS);
	localparam logic [13:0] W3 = 14'(16777216 % CHANNELS);
	localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(CHANNELS) - 64'd1) / CHANNELS);
	localparam logic [13:0] CH14 = 14'(CHANNELS);

	logic [15:0] base_q;
	logic [31:0] gctl_q;
	logic [31:0] csel_q;
	logic [13:0] selsum_q;
	logic [13:0] quot_q;
	logic [CW-1:0] chan_q;

	logic [63:0] src_q  [CHANNELS];
	logic [63:0] dst_q  [CHANNELS];
	logic [31:0] len_q  [CHANNELS];
	logic [31:0] cctl_q [CHANNELS];
	logic [31:0] attr_q [CHANNELS];
	logic [31:0] fill_q [CHANNELS];
	logic [2:0]  flg_q  [CHANNELS];

	logic [CW-1:0] act_q;
	logic [63:0]   ws_q;
	logic [63:0]   wd_q;
	logic [31:0]   rem_q;
	logic          wfill_q;
	logic [31:0]   wfw_q;

	res_t r0_q, r1_q;

	logic [15:0] off, regoff;
	logic [1:0]  lane;
	logic        hit;
	logic        busy_any, err_any;
	logic [31:0] rd32;
	logic        wr_ok, beat_copy, beat_fill, beat;
	logic [31:0] cc_new, gc_new, rem_n;
	logic        start_go;
	logic [63:0] ws_n, wd_n;
	logic [7:0]  fbyte;
	logic [46:0] prod;
	logic [13:0] rem_raw;
	res_t        r0, r1;
	logic [1:0]  nres;

	always_comb begin
		busy_any = 1'b0;
		err_any  = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			busy_any = busy_any | flg_q[i][0];
			err_any  = err_any | flg_q[i][2];
		end
	end

	always_comb begin
		off    = addr - base_q;
		hit    = {1'b0, off} < 17'(WINDOW_BYTES);
		regoff = off & REG_MASK;
		lane   = off[1:0];
		case (regoff)
			REG_ID:    rd32 = ID_VALUE;
			REG_GSTAT: rd32 = {30'd0, err_any, busy_any};
			REG_GCTL:  rd32 = {31'd0, gctl_q[0]};
			REG_CSEL:  rd32 = csel_q;
			REG_SRCL:  rd32 = src_q[chan_q][31:0];
			REG_SRCH:  rd32 = src_q[chan_q][63:32];
			REG_DSTL:  rd32 = dst_q[chan_q][31:0];
			REG_DSTH:  rd32 = dst_q[chan_q][63:32];
			REG_LEN:   rd32 = len_q[chan_q];
			REG_CCTL:  rd32 = cctl_q[chan_q];
			REG_CSTAT: rd32 = {29'd0, flg_q[chan_q]};
			REG_ATTR:  rd32 = attr_q[chan_q];
			REG_FILL:  rd32 = fill_q[chan_q];
			default:   rd32 = 32'd0;
		endcase

		wr_ok     = (cmd == CMD_WR) && hit && !busy_any;
		cc_new    = merge32(cctl_q[chan_q], wdata, lane);
		gc_new    = merge32(gctl_q, wdata, lane);
		start_go  = wr_ok && (regoff == REG_CCTL) && cc_new[0] && gctl_q[0]
			&& (len_q[chan_q] != 32'd0);
		beat_copy = (cmd == CMD_MRD) && busy_any && !wfill_q && (rem_q != 32'd0);
		beat_fill = (cmd == CMD_TICK) && busy_any && wfill_q && (rem_q != 32'd0);
		beat      = beat_copy || beat_fill;
		rem_n     = rem_q - 32'd1;
		ws_n      = beat_copy ? ws_q + 64'd1 : ws_q;
		wd_n      = wd_q + 64'd1;
		fbyte     = wfw_q[{wd_q[1:0], 3'b000} +: 8];

		r0   = '0;
		r1   = '0;
		nres = 2'd0;
		if (cmd == CMD_RD || cmd == CMD_WR) begin
			r0.kind  = KIND_RESP;
			r0.hit   = hit;
			r0.rdata = (cmd == CMD_RD && hit) ? rd32[{lane, 3'b000} +: 8] : 8'd0;
			nres     = 2'd1;
			if (start_go && !cc_new[1]) begin
				r1.kind     = KIND_MRD;
				r1.mem_addr = src_q[chan_q][15:0];
				nres        = 2'd2;
			end
		end else if (beat) begin
			r0.kind      = KIND_MWR;
			r0.mem_addr  = wd_q[15:0];
			r0.mem_wdata = beat_copy ? mem_rdata : fbyte;
			r0.last      = (rem_n == 32'd0);
			nres         = 2'd1;
			if (beat_copy && rem_n != 32'd0) begin
				r1.kind     = KIND_MRD;
				r1.mem_addr = ws_n[15:0];
				nres        = 2'd2;
			end
		end
		sts.nres = nres;
		sts.selw = wr_ok && (regoff == REG_CSEL);
		res      = ctl.sel1 ? r1_q : r0_q;
	end

	// channel select mod CHANNELS: weighted byte sum, reciprocal multiply, fix-up
	assign prod    = 47'(selsum_q) * 47'(RECIP);
	assign rem_raw = selsum_q - 14'(quot_q * CH14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selsum_q <= '0;
			quot_q   <= '0;
			chan_q   <= '0;
		end else begin
			selsum_q <= 14'(csel_q[7:0]) * W0 + 14'(csel_q[15:8]) * W1
				+ 14'(csel_q[23:16]) * W2 + 14'(csel_q[31:24]) * W3;
			quot_q   <= prod[45:32];
			chan_q   <= (rem_raw >= CH14) ? CW'(rem_raw - CH14) : CW'(rem_raw);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			r0_q <= r0;
			r1_q <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			gctl_q  <= '0;
			csel_q  <= '0;
			act_q   <= '0;
			ws_q    <= '0;
			wd_q    <= '0;
			rem_q   <= '0;
			wfill_q <= 1'b0;
			wfw_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				src_q[i]  <= '0;
				dst_q[i]  <= '0;
				len_q[i]  <= '0;
				cctl_q[i] <= '0;
				attr_q[i] <= '0;
				fill_q[i] <= '0;
				flg_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) base_q <= cfg_data;
			if (ctl.acc && wr_ok) begin
				case (regoff)
					REG_GCTL: begin
						gctl_q <= {gc_new[31:2], 1'b0, gc_new[0]};
						if (gc_new[1]) begin
							for (int i = 0; i < CHANNELS; i++) flg_q[i] <= flg_q[i] & FL_BUSY;
						end
					end
					REG_CSEL: csel_q <= merge32(csel_q, wdata, lane);
					REG_SRCL: src_q[chan_q][31:0]  <= merge32(src_q[chan_q][31:0], wdata, lane);
					REG_SRCH: src_q[chan_q][63:32] <= merge32(src_q[chan_q][63:32], wdata, lane);
					REG_DSTL: dst_q[chan_q][31:0]  <= merge32(dst_q[chan_q][31:0], wdata, lane);
					REG_DSTH: dst_q[chan_q][63:32] <= merge32(dst_q[chan_q][63:32], wdata, lane);
					REG_LEN:  len_q[chan_q] <= merge32(len_q[chan_q], wdata, lane);
					REG_CCTL: begin
						cctl_q[chan_q] <= {cc_new[31:1], 1'b0};
						if (cc_new[0]) begin
							if (!gctl_q[0]) begin
								flg_q[chan_q] <= flg_q[chan_q] | FL_DONE | FL_ERR;
							end else if (len_q[chan_q] == 32'd0) begin
								flg_q[chan_q] <= FL_DONE;
							end else begin
								flg_q[chan_q] <= FL_BUSY;
								act_q   <= chan_q;
								ws_q    <= src_q[chan_q];
								wd_q    <= dst_q[chan_q];
								rem_q   <= len_q[chan_q];
								wfill_q <= cc_new[1];
								wfw_q   <= fill_q[chan_q];
							end
						end
					end
					REG_CSTAT: flg_q[chan_q] <= flg_q[chan_q] & FL_BUSY;
					REG_ATTR:  attr_q[chan_q] <= merge32(attr_q[chan_q], wdata, lane);
					REG_FILL:  fill_q[chan_q] <= merge32(fill_q[chan_q], wdata, lane);
					default: ;
				endcase
			end else if (ctl.acc && beat) begin
				ws_q  <= ws_n;
				wd_q  <= wd_n;
				rem_q <= rem_n;
				if (rem_n == 32'd0) begin
					src_q[act_q] <= ws_n;
					dst_q[act_q] <= wd_n;
					flg_q[act_q] <= FL_DONE;
				end
			end
		end
	end
endmodule
`default_nettype wire

[src/four_channel_dma_controller_unit.sv]
// Four-channel DMA controller behind a byte-wide register window.
// Channels: req (sink) takes one word per item: register read, register
// write, returned memory read data, or a fill tick. rsp (source) gives the
// results: access responses, memory read requests and memory write requests
// (last marks the final write). cfg (sink) sets the window base address;
// it is always ready.
// Timing: results of an item appear on rsp the cycle after it is taken;
// an item gives zero, one or two result words, delivered one per cycle
// while rsp.ready is high. An item that gives no result leaves req.ready
// high, so such items go one per cycle. A write to channel select holds
// req.ready low while the select-mod-CHANNELS pipeline (three registers)
// settles. Work is one item at a time: req.ready is low until every
// result of the current item has been taken.
// Reset clears flags, base address and config registers; rsp.valid drops.
// When rsp.ready is low the result word holds and no new item is taken.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_dma_controller_unit #(
	parameter int CHANNELS     = 4,
	parameter int WINDOW_BYTES = 256
) (
	input wire          clk,
	input wire          arst_n,
	dma4_req_if.sink    req,
	dma4_rsp_if.source  rsp,
	dma4_cfg_if.sink    cfg
);
	import dma4_pkg::*;

	ctl_t ctl;
	sts_t sts;
	res_t res;

	// base address register takes every write
	assign cfg.ready = 1'b1;

	dma4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	dma4_dpath #(
		.CHANNELS     (CHANNELS),
		.WINDOW_BYTES (WINDOW_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (req.cmd),
		.addr      (req.addr),
		.wdata     (req.wdata),
		.mem_rdata (req.mem_rdata),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.ctl       (ctl),
		.sts       (sts),
		.res       (res)
	);

	// result word fields
	assign rsp.kind      = res.kind;
	assign rsp.hit       = res.hit;
	assign rsp.rdata     = res.rdata;
	assign rsp.mem_addr  = res.mem_addr;
	assign rsp.mem_wdata = res.mem_wdata;
	assign rsp.last      = res.last;
endmodule
`default_nettype wire

[src/dma4_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module dma4_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [1:0]  kind,
	input wire        hit,
	input wire [7:0]  rdata,
	input wire [15:0] mem_addr,
	input wire [7:0]  mem_wdata,
	input wire        last
);
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid)
		else $error("item taken while result pending");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind != 2'd3))
		else $error("illegal kind");

	a_resp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == 2'd0) |-> (mem_addr == 16'd0 && mem_wdata == 8'd0 && !last))
		else $error("response carries memory fields");

	a_req_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != 2'd0) |-> (!hit && rdata == 8'd0))
		else $error("request carries access fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(mem_addr)))
		else $error("stalled word changed");
endmodule

bind four_channel_dma_controller_unit dma4_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.kind      (rsp.kind),
	.hit       (rsp.hit),
	.rdata     (rsp.rdata),
	.mem_addr  (rsp.mem_addr),
	.mem_wdata (rsp.mem_wdata),
	.last      (rsp.last)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import dma4_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dma4_req_if req ();
	dma4_rsp_if rsp ();
	dma4_cfg_if cfg ();

	four_channel_dma_controller_unit DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [7:0]  mem_rdata;
	} word_t;

	// ---------------------------------------------------------------------------
	// Predictor state: shadow copy of the block's registers
	// ---------------------------------------------------------------------------
	logic [15:0] base_q = 16'd0;
	logic [31:0] gctl_q = 32'd0, csel_q = 32'd0;
	logic [63:0] src_q [4] = '{default: '0};
	logic [63:0] dst_q [4] = '{default: '0};
	logic [31:0] len_q [4] = '{default: '0};
	logic [31:0] cctl_q [4] = '{default: '0};
	logic [31:0] attr_q [4] = '{default: '0};
	logic [31:0] fill_q [4] = '{default: '0};
	logic [2:0]  flags_q [4] = '{default: '0};
	logic [1:0]  act_q = 2'd0;
	logic [63:0] wsrc_q = 64'd0, wdst_q = 64'd0;
	logic [31:0] remain_q = 32'd0;

	res_t expected_words [$];
	word_t pending_items [$];

	int  fails = 0;
	int  send_idle = 0;   // percent
	int  recv_stall = 0;  // percent
	int  quiet = 0;

	function automatic logic any_busy();
		for (int i = 0; i < 4; i++)
			if (flags_q[i] & FL_BUSY) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [31:0] reg_value(input logic [15:0] r);
		logic [1:0] c;
		logic [31:0] st;
		c = csel_q[1:0];
		st = 0;
		case (r)
			REG_ID: return ID_VALUE;
			REG_GSTAT: begin
				for (int i = 0; i < 4; i++) begin
					if (flags_q[i] & FL_BUSY) st[0] = 1'b1;
					if (flags_q[i] & FL_ERR) st[1] = 1'b1;
				end
				return st;
			end
			REG_GCTL: return {31'd0, gctl_q[0]};
			REG_CSEL: return csel_q;
			REG_SRCL: return src_q[c][31:0];
			REG_SRCH: return src_q[c][63:32];
			REG_DSTL: return dst_q[c][31:0];
			REG_DSTH: return dst_q[c][63:32];
			REG_LEN: return len_q[c];
			REG_CCTL: return cctl_q[c];
			REG_CSTAT: return {29'd0, flags_q[c]};
			REG_ATTR: return attr_q[c];
			REG_FILL: return fill_q[c];
			default: return 0;
		endcase
	endfunction

	function automatic res_t mk(input logic [1:0] k, input logic h, input logic [7:0] rd,
		input logic [15:0] ma, input logic [7:0] mw, input logic l);
		res_t r;
		r.kind = k; r.hit = h; r.rdata = rd; r.mem_addr = ma; r.mem_wdata = mw; r.last = l;
		return r;
	endfunction

	function automatic logic [31:0] lane_put(input logic [31:0] o, input logic [7:0] b,
		input int sh);
		logic [31:0] r;
		r = o;
		r[sh +: 8] = b;
		return r;
	endfunction

	// one data beat of a running transfer
	task automatic emit_beat(input logic [7:0] b, input logic copy);
		logic [63:0] d;
		d = wdst_q;
		if (copy) wsrc_q = wsrc_q + 1;
		wdst_q = wdst_q + 1;
		remain_q = remain_q - 1;
		expected_words.push_back(mk(KIND_MWR, 0, 0, d[15:0], b, remain_q == 0));
		if (remain_q == 0) begin
			src_q[act_q] = wsrc_q;
			dst_q[act_q] = wdst_q;
			flags_q[act_q] = FL_DONE;
		end
	endtask

	task automatic start_channel(input logic [1:0] c);
		if (!gctl_q[0]) begin
			flags_q[c] = flags_q[c] | FL_DONE | FL_ERR;
		end else if (len_q[c] == 0) begin
			flags_q[c] = FL_DONE;
		end else begin
			flags_q[c] = FL_BUSY;
			act_q = c;
			wsrc_q = src_q[c];
			wdst_q = dst_q[c];
			remain_q = len_q[c];
			if (!cctl_q[c][1])
				expected_words.push_back(mk(KIND_MRD, 0, 0, wsrc_q[15:0], 0, 0));
		end
	endtask

	task automatic predict_item(input word_t w);
		logic [15:0] off, r;
		logic hit;
		int sh, sh64;
		logic [1:0] c;
		logic running, fill;
		off = w.addr - base_q;
		hit = off < 16'd256;
		r = off & REG_MASK;
		sh = off[1:0] * 8;
		c = csel_q[1:0];
		running = flags_q[act_q][0];
		fill = cctl_q[act_q][1];
		case (cmd_t'(w.cmd))
			CMD_RD: begin
				expected_words.push_back(mk(KIND_RESP, hit,
					hit ? 8'(reg_value(r) >> sh) : 8'd0, 0, 0, 0));
			end
			CMD_WR: begin
				expected_words.push_back(mk(KIND_RESP, hit, 0, 0, 0, 0));
				if (hit && !any_busy()) begin
					case (r)
						REG_GCTL: begin
							gctl_q = lane_put(gctl_q, w.wdata, sh);
							if (gctl_q[1]) begin
								for (int i = 0; i < 4; i++)
									flags_q[i] = flags_q[i] & FL_BUSY;
								gctl_q[1] = 1'b0;
							end
						end
						REG_CSEL: csel_q = lane_put(csel_q, w.wdata, sh);
						REG_SRCL: src_q[c][sh +: 8] = w.wdata;
						REG_SRCH: begin sh64 = sh + 32; src_q[c][sh64 +: 8] = w.wdata; end
						REG_DSTL: dst_q[c][sh +: 8] = w.wdata;
						REG_DSTH: begin sh64 = sh + 32; dst_q[c][sh64 +: 8] = w.wdata; end
						REG_LEN: len_q[c] = lane_put(len_q[c], w.wdata, sh);
						REG_CCTL: begin
							cctl_q[c] = lane_put(cctl_q[c], w.wdata, sh);
							if (cctl_q[c][0]) begin
								cctl_q[c][0] = 1'b0;
								start_channel(c);
							end
						end
						REG_CSTAT: flags_q[c] = flags_q[c] & FL_BUSY;
						REG_ATTR: attr_q[c] = lane_put(attr_q[c], w.wdata, sh);
						REG_FILL: fill_q[c] = lane_put(fill_q[c], w.wdata, sh);
						default: ;
					endcase
				end
			end
			CMD_MRD: begin
				if (running && !fill && remain_q != 0) begin
					emit_beat(w.mem_rdata, 1'b1);
					if (remain_q != 0)
						expected_words.push_back(mk(KIND_MRD, 0, 0, wsrc_q[15:0], 0, 0));
				end
			end
			CMD_TICK: begin
				if (running && fill && remain_q != 0)
					emit_beat(8'(fill_q[act_q] >> (wdst_q[1:0] * 8)), 1'b0);
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------------------
	// Driver: pops pending words, random idle per send_idle
	// ---------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= 0; req.addr <= 0; req.wdata <= 0; req.mem_rdata <= 0;
		end else if (!req.valid || req.ready) begin
			// word accepted (or none pending): choose next
			if (req.valid) pending_items.pop_front();
			if (pending_items.size() > (req.valid ? 0 : 0) &&
				$urandom_range(99) >= send_idle && pending_items.size() != 0) begin
				req.valid <= 1'b1;
				req.cmd <= pending_items[0].cmd;
				req.addr <= pending_items[0].addr;
				req.wdata <= pending_items[0].wdata;
				req.mem_rdata <= pending_items[0].mem_rdata;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// predictor runs on accepted words
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			predict_item('{req.cmd, req.addr, req.wdata, req.mem_rdata});
	end

	// ---------------------------------------------------------------------------
	// Monitor: checks result words against the oldest expectation
	// ---------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= $urandom_range(99) >= recv_stall;
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word kind %0d", rsp.kind);
					fails++;
				end else begin
					res_t e;
					e = expected_words.pop_front();
					if (rsp.kind !== e.kind) begin
						$error("kind exp %0h got %0h", e.kind, rsp.kind); fails++; end
					if (rsp.hit !== e.hit) begin
						$error("hit exp %0h got %0h", e.hit, rsp.hit); fails++; end
					if (rsp.rdata !== e.rdata) begin
						$error("rdata exp %0h got %0h", e.rdata, rsp.rdata); fails++; end
					if (rsp.mem_addr !== e.mem_addr) begin
						$error("mem_addr exp %0h got %0h", e.mem_addr, rsp.mem_addr);
						fails++;
					end
					if (rsp.mem_wdata !== e.mem_wdata) begin
						$error("mem_wdata exp %0h got %0h", e.mem_wdata, rsp.mem_wdata);
						fails++;
					end
					if (rsp.last !== e.last) begin
						$error("last exp %0h got %0h", e.last, rsp.last); fails++; end
				end
			end
		end
	end

	// watchdog: cycles with no word moving on req or rsp
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// config channel driven from the initial block's writes
	logic        cfg_go = 1'b0;
	logic [15:0] cfg_val = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.data <= 0;
		end else if (cfg.valid && cfg.ready) begin
			cfg.valid <= 1'b0;
			base_q <= cfg.data;
		end else if (cfg_go && !cfg.valid) begin
			cfg.valid <= 1'b1;
			cfg.data <= cfg_val;
		end
	end

	// ---------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------
	function automatic word_t wr(input int off, input logic [7:0] d);
		return '{CMD_WR, 16'(base_q + off), d, 8'($urandom())};
	endfunction

	function automatic word_t rd(input int off);
		return '{CMD_RD, 16'(base_q + off), 8'($urandom()), 8'($urandom())};
	endfunction

	task automatic queue_reg32(input int r, input logic [31:0] v);
		for (int i = 0; i < 4; i++) pending_items.push_back(wr(r + i, v[i*8 +: 8]));
	endtask

	// set up and run one transfer on channel c, feeding data/ticks
	task automatic queue_transfer(input logic [1:0] c, input logic fill, input int n);
		logic [63:0] s, d;
		s = {$urandom(), $urandom()};
		d = {$urandom(), $urandom()};
		queue_reg32(REG_CSEL, {27'd0, 3'($urandom_range(7)), c});
		pending_items.push_back(wr(REG_SRCL, s[7:0]));
		pending_items.push_back(wr(REG_SRCL + 1, s[15:8]));
		pending_items.push_back(wr(REG_SRCH + 3, s[63:56]));
		pending_items.push_back(wr(REG_DSTL, d[7:0]));
		pending_items.push_back(wr(REG_DSTL + 1, d[15:8]));
		pending_items.push_back(wr(REG_DSTH + 3, 8'hFF));
		queue_reg32(REG_LEN, n);
		if (fill) queue_reg32(REG_FILL, $urandom());
		pending_items.push_back(wr(REG_CCTL, {6'd0, fill, 1'b1}));
		// writes during busy get dropped; a read of status shows busy if the start took
		pending_items.push_back(rd(REG_GSTAT));
		if ($urandom_range(3) == 0) pending_items.push_back(wr(REG_LEN, 8'($urandom())));
		for (int i = 0; i < n + $urandom_range(2); i++) begin
			if ($urandom_range(9) == 0) pending_items.push_back(rd($urandom_range(255)));
			pending_items.push_back('{fill ? CMD_TICK : CMD_MRD, 16'($urandom()),
				8'($urandom()), 8'($urandom())});
		end
		pending_items.push_back(rd(REG_CSTAT));
		pending_items.push_back(rd(REG_SRCL + $urandom_range(3)));
		pending_items.push_back(rd(REG_DSTH + $urandom_range(3)));
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || req.valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_base(input logic [15:0] v);
		cfg_val = v;
		cfg_go = 1'b1;
		@(posedge clk);
		while (!(cfg.valid && cfg.ready)) @(posedge clk);
		cfg_go = 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] bases [4];
		bases = '{16'h0000, 16'hFFC0, 16'h8000, 16'h1234};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: start while disabled, zero length, clear, extremes
		pending_items.push_back(rd(REG_ID));
		pending_items.push_back(rd(REG_ID + 2));
		pending_items.push_back(wr(REG_CCTL, 8'h01));    // start disabled -> error
		pending_items.push_back(rd(REG_GSTAT));
		pending_items.push_back(wr(REG_GCTL, 8'h03));    // enable + clear errors
		pending_items.push_back(rd(REG_CSTAT));
		pending_items.push_back(wr(REG_CCTL, 8'h01));    // zero length -> done
		pending_items.push_back(rd(REG_CSTAT));
		pending_items.push_back(wr(REG_CSTAT, 8'hFF));
		pending_items.push_back(wr(REG_ATTR + 3, 8'hFF));
		pending_items.push_back(rd(REG_ATTR + 3));
		pending_items.push_back(rd(16'h00FF));
		pending_items.push_back('{CMD_RD, 16'hFFFF, 8'hFF, 8'hFF}); // outside
		pending_items.push_back('{CMD_WR, 16'h0100, 8'hFF, 8'hFF});
		pending_items.push_back('{CMD_MRD, 16'h0, 8'h0, 8'hFF});    // ignored
		pending_items.push_back('{CMD_TICK, 16'h0, 8'h0, 8'h0});    // ignored
		drain();
		queue_transfer(2'd1, 1'b0, 1);
		queue_transfer(2'd3, 1'b1, 3);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 59; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 59; end
				default: begin send_idle = 19; recv_stall = 19; end
			endcase
			set_base(bases[ph % 4]);
			pending_items.push_back(wr(REG_GCTL, {7'd0, ph != 5}));
			for (int t = 0; t < 2; t++) begin
				queue_transfer(2'($urandom_range(3)), 1'($urandom_range(1)),
					$urandom_range(1, 6));
				// noise
				for (int k = 0; k < 3; k++)
					pending_items.push_back('{2'($urandom()), 16'($urandom()),
						8'($urandom()), 8'($urandom())});
				pending_items.push_back(wr($urandom_range(255), 8'($urandom())));
			end
			pending_items.push_back(wr(REG_GCTL, 8'h03));
			drain();
		end
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
